// File: rtl/core/cdls_pkg.sv
// Shared types, codes and helpers for the cyclic dominance lattice step core.
package cdls_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_EVENT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] SP_EMPTY = 2'd0;
    localparam logic [1:0] SP_A     = 2'd1;
    localparam logic [1:0] SP_B     = 2'd2;
    localparam logic [1:0] SP_C     = 2'd3;

    localparam logic [2:0] DIR_PX = 3'd0;
    localparam logic [2:0] DIR_PY = 3'd1;
    localparam logic [2:0] DIR_MX = 3'd2;
    localparam logic [2:0] DIR_MY = 3'd3;
    localparam logic [2:0] DIR_PZ = 3'd4;
    localparam logic [2:0] DIR_MZ = 3'd5;

    localparam logic [2:0] OUT_NONE     = 3'd0;
    localparam logic [2:0] OUT_ATE_PREY = 3'd1;
    localparam logic [2:0] OUT_EATEN    = 3'd2;
    localparam logic [2:0] OUT_EMPTY    = 3'd3;
    localparam logic [2:0] OUT_DONE     = 3'd4;

    localparam int CNT_OUT_W = 13;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] x_coord;
        logic [3:0] y_coord;
        logic [3:0] z_coord;
        logic [2:0] direction;
        logic [1:0] species;
    } req_t;

    typedef struct packed {
        logic [2:0]           outcome;
        logic [1:0]           site_species;
        logic [CNT_OUT_W-1:0] count_a;
        logic [CNT_OUT_W-1:0] count_b;
        logic [CNT_OUT_W-1:0] count_c;
        logic                 fixation;
        logic [31:0]          events_done;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic addr;
        logic rd_here;
        logic rd_nb;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic is_event;
        logic clear_last;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_RD_HERE,
        ST_RD_NB,
        ST_EXEC
    } ctrl_state_t;

    // a eats b, b eats c, c eats a
    function automatic logic [1:0] prey_of(input logic [1:0] s);
        logic [1:0] p;
        unique case (s)
            SP_EMPTY: p = SP_A;
            SP_A:     p = SP_B;
            SP_B:     p = SP_C;
            SP_C:     p = SP_A;
            default:  p = SP_A;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/cdls_ctrl.sv
// Sequencing state machine for the lattice step core.
module cdls_ctrl
    import cdls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        req_ready      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_RD_HERE;
            end
            ST_RD_HERE:
            begin
                cmd.rd_here = 1'b1;
                state_next  = status.is_event ? ST_RD_NB : ST_EXEC;
            end
            ST_RD_NB:
            begin
                cmd.rd_nb  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

// File: rtl/core/cdls_dp.sv
// Datapath: lattice memory, species counts, event tally and result word register.
module cdls_dp
    import cdls_pkg::*;
#(
    parameter int SIDE = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  req_t       req,
    output dp_status_t status,
    output rsp_t       rsp
);

    localparam int SITES      = SIDE * SIDE * SIDE;
    localparam int AW         = $clog2(SITES);
    localparam int CW         = $clog2(SIDE);
    localparam int CNTW       = $clog2(SITES + 1);
    localparam int WRAP_STEPS = 15 / SIDE;

    logic [1:0]      site_mem [SITES];
    logic [1:0]      rdata_reg;

    logic [1:0]      cmd_reg;
    logic [2:0]      dir_reg;
    logic [1:0]      sp_reg;
    logic [CW-1:0]   x_reg, y_reg, z_reg;
    logic [AW-1:0]   here_reg, nb_reg;
    logic [1:0]      me_reg;
    logic [AW-1:0]   clr_reg;

    logic [CNTW-1:0] cnt_a_reg, cnt_b_reg, cnt_c_reg;
    logic [CNTW-1:0] cnt_a_next, cnt_b_next, cnt_c_next;
    logic [31:0]     tally_reg, tally_next;
    rsp_t            rsp_reg, rsp_next;

    logic [CW-1:0]   nx, ny, nz;
    logic [AW-1:0]   here_calc, nb_calc;
    logic [AW-1:0]   mem_addr;
    logic            mem_we;
    logic [1:0]      mem_wdata;
    logic [1:0]      sp_up, sp_dn;
    logic [2:0]      outcome;
    logic [1:0]      site_now;

    function automatic logic [CW-1:0] wrap_coord(input logic [3:0] v);
        logic [6:0] r;
        r = {3'b000, v};
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (r >= 7'(SIDE))
            begin
                r = r - 7'(SIDE);
            end
        end
        return r[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] coord_inc(input logic [CW-1:0] c);
        return (c == CW'(SIDE - 1)) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [CW-1:0] coord_dec(input logic [CW-1:0] c);
        return (c == '0) ? CW'(SIDE - 1) : c - 1'b1;
    endfunction

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return (AW'(x) * AW'(SIDE) + AW'(y)) * AW'(SIDE) + AW'(z);
    endfunction

    function automatic logic [CNTW-1:0] adjust_count(input logic [CNTW-1:0] c,
                                                     input logic [1:0] k,
                                                     input logic [1:0] up,
                                                     input logic [1:0] dn);
        logic [CNTW-1:0] t;
        t = c;
        if (dn == k && t != '0)
        begin
            t = t - 1'b1;
        end
        if (up == k && t < CNTW'(SITES))
        begin
            t = t + 1'b1;
        end
        return t;
    endfunction

    function automatic logic [CNT_OUT_W-1:0] report_count(input logic [CNTW-1:0] c);
        logic [CNTW+CNT_OUT_W-1:0] ext;
        ext = {{CNT_OUT_W{1'b0}}, c};
        return ext[CNT_OUT_W-1:0];
    endfunction

    // neighbor coordinates, periodic wrap
    always_comb
    begin
        nx = x_reg;
        ny = y_reg;
        nz = z_reg;
        priority case (dir_reg)
            DIR_PX: nx = coord_inc(x_reg);
            DIR_PY: ny = coord_inc(y_reg);
            DIR_MX: nx = coord_dec(x_reg);
            DIR_MY: ny = coord_dec(y_reg);
            DIR_PZ: nz = coord_inc(z_reg);
            DIR_MZ: nz = coord_dec(z_reg);
            default:
            begin
                nx = x_reg;
            end
        endcase
        here_calc = site_addr(x_reg, y_reg, z_reg);
        nb_calc   = site_addr(nx, ny, nz);
    end

    // resolve the command from the words read out of the lattice
    always_comb
    begin
        sp_up    = SP_EMPTY;
        sp_dn    = SP_EMPTY;
        outcome  = OUT_DONE;
        site_now = rdata_reg;
        mem_we   = 1'b0;
        mem_wdata = SP_EMPTY;
        mem_addr = here_reg;
        tally_next = tally_reg;
        priority case (cmd_reg)
            CMD_LOAD:
            begin
                sp_dn     = rdata_reg;
                sp_up     = sp_reg;
                site_now  = sp_reg;
                mem_we    = cmd.exec;
                mem_wdata = sp_reg;
            end
            CMD_EVENT:
            begin
                site_now = me_reg;
                if (tally_reg != '1)
                begin
                    tally_next = tally_reg + 1'b1;
                end
                if (me_reg == SP_EMPTY)
                begin
                    outcome = OUT_EMPTY;
                end
                else if (dir_reg > DIR_MZ)
                begin
                    outcome = OUT_NONE;
                end
                else if (rdata_reg != SP_EMPTY && rdata_reg == prey_of(me_reg))
                begin
                    outcome   = OUT_ATE_PREY;
                    sp_up     = me_reg;
                    sp_dn     = rdata_reg;
                    mem_we    = cmd.exec;
                    mem_wdata = me_reg;
                    mem_addr  = nb_reg;
                end
                else if (rdata_reg != SP_EMPTY && me_reg == prey_of(rdata_reg))
                begin
                    outcome   = OUT_EATEN;
                    sp_up     = rdata_reg;
                    sp_dn     = me_reg;
                    site_now  = rdata_reg;
                    mem_we    = cmd.exec;
                    mem_wdata = rdata_reg;
                end
                else
                begin
                    outcome = OUT_NONE;
                end
            end
            default:
            begin
                site_now = rdata_reg;
            end
        endcase

        priority if (cmd.clear)
        begin
            mem_addr  = clr_reg;
            mem_we    = 1'b1;
            mem_wdata = SP_EMPTY;
        end
        else if (cmd.rd_here)
        begin
            mem_addr = here_reg;
        end
        else if (cmd.rd_nb)
        begin
            mem_addr = nb_reg;
        end

        cnt_a_next = adjust_count(cnt_a_reg, SP_A, sp_up, sp_dn);
        cnt_b_next = adjust_count(cnt_b_reg, SP_B, sp_up, sp_dn);
        cnt_c_next = adjust_count(cnt_c_reg, SP_C, sp_up, sp_dn);

        rsp_next.outcome      = outcome;
        rsp_next.site_species = site_now;
        rsp_next.count_a      = report_count(cnt_a_next);
        rsp_next.count_b      = report_count(cnt_b_next);
        rsp_next.count_c      = report_count(cnt_c_next);
        rsp_next.fixation     = (cnt_a_next == CNTW'(SITES)) ||
                                (cnt_b_next == CNTW'(SITES)) ||
                                (cnt_c_next == CNTW'(SITES));
        rsp_next.events_done  = tally_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            site_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd_here || cmd.rd_nb)
        begin
            rdata_reg <= site_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= req.cmd;
            dir_reg <= req.direction;
            sp_reg  <= req.species;
            x_reg   <= wrap_coord(req.x_coord);
            y_reg   <= wrap_coord(req.y_coord);
            z_reg   <= wrap_coord(req.z_coord);
        end
        if (cmd.addr)
        begin
            here_reg <= here_calc;
            nb_reg   <= nb_calc;
        end
        if (cmd.rd_nb)
        begin
            me_reg <= rdata_reg;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            cnt_c_reg <= '0;
            tally_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                cnt_a_reg <= cnt_a_next;
                cnt_b_reg <= cnt_b_next;
                cnt_c_reg <= cnt_c_next;
                tally_reg <= tally_next;
            end
        end
    end

    assign status.is_event   = (cmd_reg == CMD_EVENT);
    assign status.clear_last = (clr_reg == AW'(SITES - 1));
    assign rsp               = rsp_reg;

endmodule

// File: rtl/core/cyclic_dominance_lattice_step_core.sv
// Top level of the cyclic dominance lattice step core.
//
// Request channel (req_valid/req_ready/req) carries one command word: load a
// site, run one predation event against a wrapped neighbor, or read a site.
// Response channel (rsp_valid/rsp_ready/rsp) returns exactly one word per
// command: outcome, species now at the chosen site, species counts, the
// fixation flag and the saturating event tally.
// Each command runs through forming the addresses, one access to the chosen
// site, one to the neighbor (events only) and a final step that writes back
// where needed and registers the answer; the next command is taken in the
// cycle after the answer is registered. The single-port lattice memory sets
// this sequence.
// Reset clears counts and tally, then a clearing pass writes every site
// empty with req_ready low.
// A stalled receiver holds rsp; one further command is accepted and worked
// up to its write-back, which waits until the held word is taken.
module cyclic_dominance_lattice_step_core
    import cdls_pkg::*;
#(
    parameter int SIDE = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    cdls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cdls_dp #(
        .SIDE (SIDE)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .status (status),
        .rsp    (rsp)
    );

endmodule

// File: dv/cyclic_dominance_lattice_step_core_test.sv
// Self-checking testbench for the cyclic dominance lattice step core.
`timescale 1ns / 100ps

module cyclic_dominance_lattice_step_core_test;
    import cdls_pkg::*;

    localparam int          SIDE       = 16;
    localparam int unsigned SITES      = SIDE * SIDE * SIDE;
    localparam logic [1:0]  CMD_SPARE  = 2'd3;
    localparam logic [2:0]  DIR_BAD_LO = 3'd6;
    localparam logic [2:0]  DIR_BAD_HI = 3'd7;
    localparam int          STALL_LIMIT = 20000;
    localparam int          SETTLE_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [1:0]  lattice [SITES];
    int unsigned census [4];
    logic [31:0] event_cnt;
    rsp_t        pending_reports [$];

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int quiet_cycles = 0;
    rsp_t want;

    cyclic_dominance_lattice_step_core #(.SIDE(SIDE)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [1:0] eaten_by(input logic [1:0] s);
        case (s)
            SP_A:    return SP_B;
            SP_B:    return SP_C;
            SP_C:    return SP_A;
            default: return SP_EMPTY;
        endcase
    endfunction

    function automatic void census_move(input logic [1:0] s, input logic up);
        if (s == SP_EMPTY)
            return;
        if (up && census[s] < SITES)
            census[s]++;
        else if (!up && census[s] > 0)
            census[s]--;
    endfunction

    function automatic int unsigned site_addr(input int unsigned x, y, z);
        return (x * SIDE + y) * SIDE + z;
    endfunction

    // lattice update for one accepted word; returns the word the block must answer
    function automatic rsp_t apply_command(input req_t w);
        rsp_t        r;
        int unsigned x, y, z, nx, ny, nz, here, there;
        logic [1:0]  mine, theirs;
        x = w.x_coord % SIDE;
        y = w.y_coord % SIDE;
        z = w.z_coord % SIDE;
        here = site_addr(x, y, z);
        r = '0;
        r.outcome = OUT_DONE;
        if (w.cmd == CMD_LOAD)
        begin
            census_move(lattice[here], 1'b0);
            lattice[here] = w.species;
            census_move(w.species, 1'b1);
        end
        else if (w.cmd == CMD_EVENT)
        begin
            mine = lattice[here];
            if (event_cnt != 32'hFFFF_FFFF)
                event_cnt++;
            if (mine == SP_EMPTY)
                r.outcome = OUT_EMPTY;
            else if (w.direction > DIR_MZ)
                r.outcome = OUT_NONE;
            else
            begin
                nx = x;
                ny = y;
                nz = z;
                case (w.direction)
                    DIR_PX:  nx = (x + 1) % SIDE;
                    DIR_PY:  ny = (y + 1) % SIDE;
                    DIR_MX:  nx = (x + SIDE - 1) % SIDE;
                    DIR_MY:  ny = (y + SIDE - 1) % SIDE;
                    DIR_PZ:  nz = (z + 1) % SIDE;
                    default: nz = (z + SIDE - 1) % SIDE;
                endcase
                there = site_addr(nx, ny, nz);
                theirs = lattice[there];
                if (theirs != SP_EMPTY && theirs == eaten_by(mine))
                begin
                    lattice[there] = mine;
                    census_move(mine, 1'b1);
                    census_move(theirs, 1'b0);
                    r.outcome = OUT_ATE_PREY;
                end
                else if (theirs != SP_EMPTY && mine == eaten_by(theirs))
                begin
                    lattice[here] = theirs;
                    census_move(theirs, 1'b1);
                    census_move(mine, 1'b0);
                    r.outcome = OUT_EATEN;
                end
                else
                    r.outcome = OUT_NONE;
            end
        end
        r.site_species = lattice[here];
        r.count_a = CNT_OUT_W'(census[SP_A]);
        r.count_b = CNT_OUT_W'(census[SP_B]);
        r.count_c = CNT_OUT_W'(census[SP_C]);
        r.fixation = (census[SP_A] == SITES) || (census[SP_B] == SITES) ||
                     (census[SP_C] == SITES);
        r.events_done = event_cnt;
        return r;
    endfunction

    function automatic req_t word_of(input logic [1:0] c, input int x, y, z,
                                     input logic [2:0] d, input logic [1:0] s);
        req_t w;
        w.cmd = c;
        w.x_coord = 4'(x);
        w.y_coord = 4'(y);
        w.z_coord = 4'(z);
        w.direction = d;
        w.species = s;
        return w;
    endfunction

    // mostly near the wrap seam so that sites meet populated neighbors
    function automatic logic [3:0] pick_coord();
        if ($urandom_range(3) != 0)
            return 4'($urandom_range(3) + 14);
        return 4'($urandom_range(15));
    endfunction

    function automatic req_t rand_word();
        req_t w;
        int   r;
        r = $urandom_range(99);
        w.cmd = (r < 35) ? CMD_LOAD : (r < 80) ? CMD_EVENT : (r < 95) ? CMD_READ : CMD_SPARE;
        w.x_coord = pick_coord();
        w.y_coord = pick_coord();
        w.z_coord = pick_coord();
        w.direction = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                               : 3'($urandom_range(5));
        w.species = 2'($urandom_range(3));
        return w;
    endfunction

    task automatic send_word(input req_t w);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req = w;
        do
            @(posedge clk);
        while (!req_ready);
        pending_reports.push_back(apply_command(w));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        wait (pending_reports.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pacing(input int src, input int snk);
        src_idle_pct = src;
        snk_stall_pct = snk;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v, got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic test_directed();
        set_pacing(0, 0);
        send_word(word_of(CMD_READ, 0, 0, 0, DIR_PX, SP_EMPTY));
        send_word(word_of(CMD_SPARE, 15, 15, 15, DIR_BAD_HI, SP_C));
        send_word(word_of(CMD_EVENT, 15, 0, 15, DIR_BAD_HI, SP_C));
        send_word(word_of(CMD_LOAD, 0, 0, 0, DIR_PX, SP_A));
        send_word(word_of(CMD_LOAD, 15, 0, 0, DIR_PX, SP_B));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_MX, SP_EMPTY));
        send_word(word_of(CMD_LOAD, 0, 15, 0, DIR_PX, SP_C));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_MY, SP_B));
        send_word(word_of(CMD_LOAD, 0, 1, 0, DIR_PX, SP_C));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_PY, SP_A));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_PX, SP_C));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_BAD_LO, SP_EMPTY));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_BAD_HI, SP_A));
        send_word(word_of(CMD_LOAD, 0, 0, 15, DIR_PX, SP_A));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_MZ, SP_EMPTY));
        send_word(word_of(CMD_LOAD, 0, 0, 1, DIR_PX, SP_B));
        send_word(word_of(CMD_EVENT, 0, 0, 0, DIR_PZ, SP_EMPTY));
        send_word(word_of(CMD_LOAD, 0, 0, 0, DIR_PX, SP_EMPTY));
        send_word(word_of(CMD_LOAD, 0, 0, 0, DIR_PX, SP_EMPTY));
        send_word(word_of(CMD_LOAD, 15, 15, 15, DIR_BAD_HI, SP_C));
        send_word(word_of(CMD_LOAD, 15, 15, 15, DIR_BAD_HI, SP_C));
        send_word(word_of(CMD_LOAD, 0, 15, 15, DIR_PX, SP_B));
        send_word(word_of(CMD_EVENT, 15, 15, 15, DIR_PX, SP_B));
        send_word(word_of(CMD_READ, 0, 15, 15, DIR_MZ, SP_C));
        wait_drained();
    endtask

    task automatic test_random(input int count, input int src, input int snk);
        set_pacing(src, snk);
        repeat (count)
            send_word(rand_word());
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_pacing(0, 0);
        @(negedge clk);
        hold_left = 80;
        repeat (12)
            send_word(rand_word());
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready = 1'b0;
            hold_left--;
        end
        else
            rsp_ready = ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t ns: word with none expected, actual %p", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("outcome", want.outcome, rsp.outcome);
                compare_field("site_species", want.site_species, rsp.site_species);
                compare_field("count_a", want.count_a, rsp.count_a);
                compare_field("count_b", want.count_b, rsp.count_b);
                compare_field("count_c", want.count_c, rsp.count_c);
                compare_field("fixation", want.fixation, rsp.fixation);
                compare_field("events_done", want.events_done, rsp.events_done);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("cyclic_dominance_lattice_step_core verification failed");
            $finish;
        end
    end

    initial
    begin
        foreach (lattice[i])
            lattice[i] = SP_EMPTY;
        foreach (census[i])
            census[i] = 0;
        event_cnt = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(100, 0, 0);
        test_random(100, 47, 0);
        test_backpressure();
        test_random(100, 0, 47);
        test_random(100, 16, 16);

        if (pending_reports.size() != 0)
        begin
            $display("%0t ns: %0d expected words never arrived", $time,
                     pending_reports.size());
            errors++;
        end
        if (errors == 0)
            $display("cyclic_dominance_lattice_step_core verification clean");
        else
            $display("cyclic_dominance_lattice_step_core verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/cdls_pkg.sv
rtl/core/cdls_ctrl.sv
rtl/core/cdls_dp.sv
rtl/core/cyclic_dominance_lattice_step_core.sv
dv/cyclic_dominance_lattice_step_core_test.sv
